// ===== rtl/ppts_pkg.sv =====
// ppts_pkg: shared types and codes for the priority periodic task scheduler
// item and result structs, task table entry layout, item kinds, unit ops
// no dependencies
package ppts_pkg;

  localparam int SLOT_W = 4;

  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_DISP = 2'd2;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_PICK = 2'd1;
  localparam logic [1:0] OP_TAKE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] period;
    logic [7:0]  urgency;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] slot;
    logic              accepted;
  } rsp_t;

  typedef struct packed {
    logic [15:0] reload;
    logic [7:0]  rank;
    logic [15:0] countdown;
    logic [7:0]  pending;
  } entry_t;

  typedef struct packed {
    entry_t upd;
    logic   better;
  } unit_res_t;

endpackage

// ===== rtl/ppts_table.sv =====
// ppts_table: task table memory, one write port and one registered read port
// depends on ppts_pkg for the entry layout
module ppts_table
  import ppts_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ppts_unit.sv =====
// ppts_unit: shared update and compare unit used once per table entry
// countdown step for ticks, rank compare for dispatch, pending take on grant
// depends on ppts_pkg
module ppts_unit
  import ppts_pkg::*;
(
  input  logic [1:0] op,
  input  entry_t     entry,
  input  logic       found,
  input  logic [7:0] best_rank,
  output unit_res_t  res
);

  logic [15:0] cd_dec;
  logic [7:0]  pend_inc;

  assign cd_dec   = entry.countdown - 16'd1;
  assign pend_inc = (entry.pending != 8'hFF) ? entry.pending + 8'd1 : entry.pending;

  always_comb begin
    res.upd    = entry;
    res.better = 1'b0;
    case (op)
      OP_TICK: begin
        if (entry.reload != 16'd0) begin
          if (cd_dec == 16'd0) begin
            res.upd.countdown = entry.reload;
            res.upd.pending   = pend_inc;
          end else begin
            res.upd.countdown = cd_dec;
          end
        end else if (entry.countdown != 16'd0) begin
          res.upd.countdown = cd_dec;
          if (cd_dec == 16'd0) begin
            res.upd.pending = pend_inc;
          end
        end
      end
      OP_PICK: begin
        res.better = (entry.pending != 8'd0) && (!found || (best_rank > entry.rank));
      end
      OP_TAKE: begin
        res.upd.pending = entry.pending - 8'd1;
      end
      default: begin
        res.upd = entry;
      end
    endcase
  end

endmodule

// ===== rtl/priority_periodic_task_scheduler.sv =====
// priority_periodic_task_scheduler: task table with add, tick and dispatch
// result path: add goes straight to done; tick and dispatch scan the n stored tasks, n = tasks,
// then a dispatch grant passes the take state, and a scan with no tasks stored reads no entry
// throughput: one item at a time, next item taken from the cycle a result is offered;
// the table scan reads one entry per cycle from one port, a held result stalls the next one
// reset: control state and task count cleared, table contents left undefined
// depends on ppts_pkg, ppts_table, ppts_unit
module priority_periodic_task_scheduler
  import ppts_pkg::*;
#(
  parameter int TASK_SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TASK_SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_TAKE = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] used;
  logic [1:0]       op_kind;
  logic [CNT_W-1:0] scan_cnt;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_addr_q;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  entry_t           best;
  rsp_t             res;

  logic             accept;
  logic             add_ok;
  logic             rsp_load;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [1:0]       unit_op;
  entry_t           unit_in;
  unit_res_t        unit_out;
  logic [IDX_W+3:0] used_ext;
  logic [IDX_W+3:0] best_ext;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign add_ok    = accept && (req.kind == KIND_ADD) && (used < SLOTS_C);
  assign rsp_load  = (state == ST_DONE) && (!rsp_valid || rsp_ready);
  assign used_ext  = {4'b0, used[IDX_W-1:0]};
  assign best_ext  = {4'b0, best_idx};

  assign rd_en   = (state == ST_SCAN) && (scan_cnt < used);
  assign rd_addr = scan_cnt[IDX_W-1:0];

  assign unit_op = (state == ST_TAKE) ? OP_TAKE :
                   (op_kind == KIND_TICK) ? OP_TICK : OP_PICK;
  assign unit_in = (state == ST_TAKE) ? best : rd_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_q;
    wr_data = unit_out.upd;
    if (add_ok) begin
      wr_en   = 1'b1;
      wr_addr = used[IDX_W-1:0];
      wr_data = '{reload: req.period, rank: req.urgency, countdown: 16'd1, pending: 8'd1};
    end else if (state == ST_SCAN && rd_valid && op_kind == KIND_TICK) begin
      wr_en = 1'b1;
    end else if (state == ST_TAKE) begin
      wr_en   = 1'b1;
      wr_addr = best_idx;
    end
  end

  ppts_table #(
    .DEPTH (TASK_SLOTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ppts_unit u_unit (
    .op        (unit_op),
    .entry     (unit_in),
    .found     (found),
    .best_rank (best.rank),
    .res       (unit_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      scan_cnt  <= '0;
      rd_valid  <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_kind  <= req.kind;
            scan_cnt <= '0;
            found    <= 1'b0;
            if (req.kind == KIND_TICK || req.kind == KIND_DISP) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
            if (add_ok) begin
              used <= used + CNT_W'(1);
              res  <= '{granted: 1'b0, slot: used_ext[3:0], accepted: 1'b1};
            end else begin
              res  <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            scan_cnt  <= scan_cnt + CNT_W'(1);
            rd_addr_q <= rd_addr;
          end
          if (rd_valid && op_kind == KIND_DISP && unit_out.better) begin
            found    <= 1'b1;
            best_idx <= rd_addr_q;
            best     <= rd_data;
          end
          if (!rd_en && !rd_valid) begin
            state <= (op_kind == KIND_DISP && found) ? ST_TAKE : ST_DONE;
          end
        end
        ST_TAKE: begin
          res   <= '{granted: 1'b1, slot: best_ext[3:0], accepted: 1'b0};
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (rsp_load) begin
            rsp   <= res;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst) used <= SLOTS_C)
    else $error("task count beyond table size");

  a_take_found: assert property (@(posedge clk) disable iff (rst)
    state == ST_TAKE |-> found)
    else $error("grant without a pending task");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> state == ST_SCAN)
    else $error("table read data outside a scan");

  a_add_count: assert property (@(posedge clk) disable iff (rst)
    add_ok |=> used == CNT_W'($past(used) + CNT_W'(1)))
    else $error("add did not bump task count");

endmodule
